@@ design/sha1_pkg.sv @@
// ----------------------------------------------------------------------------
// sha1 package
// shared constants, queue entry type and round helpers of the sha-1 core
// ----------------------------------------------------------------------------
package sha1_pkg;

	localparam int WordW     = 32;
	localparam int BlockLen  = 16;
	localparam int Rounds    = 80;
	localparam int ChainLen  = 5;
	localparam int QDepth    = 2;

	localparam int CountW    = $clog2(BlockLen);
	localparam int RoundW    = $clog2(Rounds);
	localparam int IndexW    = 3;
	localparam int QPtrW     = $clog2(QDepth);
	localparam int QCountW   = $clog2(QDepth + 1);

	localparam logic [CountW-1:0] CountLast = CountW'(BlockLen - 1);
	localparam logic [RoundW-1:0] RoundLast = RoundW'(Rounds - 1);
	localparam logic [IndexW-1:0] IndexLast = IndexW'(ChainLen - 1);

	localparam logic [WordW-1:0] Iv [ChainLen] = '{
		32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
	};

	localparam logic [WordW-1:0] K0 = 32'h5A82_7999;
	localparam logic [WordW-1:0] K1 = 32'h6ED9_EBA1;
	localparam logic [WordW-1:0] K2 = 32'h8F1B_BCDC;
	localparam logic [WordW-1:0] K3 = 32'hCA62_C1D6;

	// one classified request, handed from front to back
	typedef struct packed {
		logic [WordW-1:0] word;
		logic             restart;
		logic             block_end;
		logic             final_mark;
	} sha1_entry_t;

	function automatic logic [WordW-1:0] round_const(input logic [RoundW-1:0] t);
		logic [WordW-1:0] k;
		if (t < RoundW'(20)) begin
			k = K0;
		end else if (t < RoundW'(40)) begin
			k = K1;
		end else if (t < RoundW'(60)) begin
			k = K2;
		end else begin
			k = K3;
		end
		return k;
	endfunction

	function automatic logic [WordW-1:0] round_fn(input logic [RoundW-1:0] t,
		input logic [WordW-1:0] b, input logic [WordW-1:0] c,
		input logic [WordW-1:0] d);
		logic [WordW-1:0] f;
		if (t < RoundW'(20)) begin
			f = (b & c) | (~b & d);
		end else if (t < RoundW'(40)) begin
			f = b ^ c ^ d;
		end else if (t < RoundW'(60)) begin
			f = (b & c) | (b & d) | (c & d);
		end else begin
			f = b ^ c ^ d;
		end
		return f;
	endfunction

endpackage

@@ design/sha1_if.sv @@
// ----------------------------------------------------------------------------
// sha1 channel interfaces
// valid/ready channels for message words and digest words
// ----------------------------------------------------------------------------
interface sha1_msg_if import sha1_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [WordW-1:0] msg_word;
	logic             new_message;
	logic             final_word;

	modport source (output valid, msg_word, new_message, final_word, input ready);
	modport sink   (input valid, msg_word, new_message, final_word, output ready);
endinterface

interface sha1_dig_if import sha1_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WordW-1:0]  digest_word;
	logic [IndexW-1:0] digest_index;
	logic              digest_last;

	modport source (output valid, digest_word, digest_index, digest_last, input ready);
	modport sink   (input valid, digest_word, digest_index, digest_last, output ready);
endinterface

@@ design/sha1_hash_core.sv @@
// ----------------------------------------------------------------------------
// sha1 hash core
// sha-1 compression over padded 32-bit big-endian words, digest as five words
// ----------------------------------------------------------------------------
// processing: a block's sixteenth word starts the rounds, then the add step
// rounds: the single round engine does one round per cycle, and the back takes no
//   new word until a block's rounds and add are done; the queue fills meanwhile
// digest: five words, one per cycle while dig.ready is high, from the output
//   register; a final request that closes a block runs rounds and add first
// reset: arst_n clears control, queue and loads the standard initial values
// ----------------------------------------------------------------------------
module sha1_hash_core import sha1_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	sha1_msg_if.sink    msg,
	sha1_dig_if.source  dig
);

	// front to queue
	logic        push;
	sha1_entry_t push_entry;
	logic        q_full;

	// queue to back
	logic        pop;
	sha1_entry_t pop_entry;
	logic        q_empty;

	// front: takes each request, tags block end, restart and final mark
	sha1_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg        (msg),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full)
	);

	// short queue so the front keeps taking words while rounds run, until it is full
	sha1_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.empty      (q_empty)
	);

	// back: collects the block, runs rounds, updates chaining, sends digest
	sha1_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_entry  (pop_entry),
		.q_empty    (q_empty),
		.pop        (pop),
		.dig        (dig)
	);

endmodule

@@ design/sha1_front.sv @@
// ----------------------------------------------------------------------------
// sha1 front
// accepts message words, tracks the position in the block, tags requests
// ----------------------------------------------------------------------------
module sha1_front import sha1_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	sha1_msg_if.sink      msg,
	output logic          push,
	output sha1_entry_t   push_entry,
	input  logic          q_full
);

	logic [CountW-1:0] word_count_q;
	logic [CountW-1:0] count_eff;

	assign msg.ready = !q_full;
	assign push      = msg.valid && !q_full;

	// a new message restarts the block position
	assign count_eff = msg.new_message ? '0 : word_count_q;

	always_comb begin
		push_entry.word       = msg.msg_word;
		push_entry.restart    = msg.new_message;
		push_entry.block_end  = (count_eff == CountLast);
		push_entry.final_mark = msg.final_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_count_q <= '0;
		end else if (push) begin
			// a final mark drops any partial block
			word_count_q <= msg.final_word ? '0 : count_eff + CountW'(1);
		end
	end

endmodule

@@ design/sha1_queue.sv @@
// ----------------------------------------------------------------------------
// sha1 queue
// short fifo of tagged requests between front and back
// ----------------------------------------------------------------------------
module sha1_queue import sha1_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  sha1_entry_t  push_entry,
	output logic         full,
	input  logic         pop,
	output sha1_entry_t  pop_entry,
	output logic         empty
);

	sha1_entry_t        mem_q [QDepth];
	logic [QPtrW-1:0]   wr_ptr_q;
	logic [QPtrW-1:0]   rd_ptr_q;
	logic [QCountW-1:0] count_q;

	assign full      = (count_q == QCountW'(QDepth));
	assign empty     = (count_q == '0);
	assign pop_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCountW'(1);
				2'b01:   count_q <= count_q - QCountW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ design/sha1_back.sv @@
// ----------------------------------------------------------------------------
// sha1 back
// schedule window, round engine, chaining state and digest output
// ----------------------------------------------------------------------------
module sha1_back import sha1_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  sha1_entry_t  pop_entry,
	input  logic         q_empty,
	output logic         pop,
	sha1_dig_if.source   dig
);

	typedef enum logic [3:0] {
		ST_LOAD  = 4'b0001,
		ST_ROUND = 4'b0010,
		ST_ADD   = 4'b0100,
		ST_OUT   = 4'b1000
	} back_state_t;

	back_state_t       state_q;
	logic [RoundW-1:0] round_q;
	logic [IndexW-1:0] out_idx_q;
	logic              final_pend_q;
	logic [WordW-1:0]  chain_q [ChainLen];
	logic [WordW-1:0] sched_q [BlockLen];
	logic [WordW-1:0]  a_q, b_q, c_q, d_q, e_q;
	logic              out_valid_q;
	logic [WordW-1:0]  out_word_q;
	logic [IndexW-1:0] out_index_q;
	logic              out_last_q;

	logic [WordW-1:0] sched_mix;
	logic [WordW-1:0] sched_next;
	logic [WordW-1:0] temp;
	logic             out_load;

	assign pop = (state_q == ST_LOAD) && !q_empty;

	// next schedule word from the sliding window
	assign sched_mix  = sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0];
	assign sched_next = {sched_mix[WordW-2:0], sched_mix[WordW-1]};

	assign temp = {a_q[WordW-6:0], a_q[WordW-1:WordW-5]}
		+ round_fn(round_q, b_q, c_q, d_q) + e_q + sched_q[0] + round_const(round_q);

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || dig.ready);

	assign dig.valid        = out_valid_q;
	assign dig.digest_word  = out_word_q;
	assign dig.digest_index = out_index_q;
	assign dig.digest_last  = out_last_q;

	// schedule window: shifts in words, then slides through the rounds
	always_ff @(posedge clk) begin
		if (pop || (state_q == ST_ROUND)) begin
			for (int i = 0; i < BlockLen - 1; i++) begin
				sched_q[i] <= sched_q[i+1];
			end
			sched_q[BlockLen-1] <= pop ? pop_entry.word : sched_next;
		end
	end

	// working variables
	always_ff @(posedge clk) begin
		if (pop && pop_entry.block_end) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (state_q == ST_ROUND) begin
			a_q <= temp;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[WordW-1:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	// digest output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_word_q  <= chain_q[out_idx_q];
			out_index_q <= out_idx_q;
			out_last_q  <= (out_idx_q == IndexLast);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			round_q      <= '0;
			out_idx_q    <= '0;
			final_pend_q <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < ChainLen; i++) begin
				chain_q[i] <= Iv[i];
			end
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (dig.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (pop) begin
						if (pop_entry.restart) begin
							for (int i = 0; i < ChainLen; i++) begin
								chain_q[i] <= Iv[i];
							end
						end
						final_pend_q <= pop_entry.final_mark;
						out_idx_q    <= '0;
						if (pop_entry.block_end) begin
							round_q <= '0;
							state_q <= ST_ROUND;
						end else if (pop_entry.final_mark) begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_ROUND: begin
					round_q <= round_q + RoundW'(1);
					if (round_q == RoundLast) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
					chain_q[4] <= chain_q[4] + e_q;
					state_q    <= final_pend_q ? ST_OUT : ST_LOAD;
				end
				ST_OUT: begin
					if (out_load) begin
						out_idx_q <= out_idx_q + IndexW'(1);
						if (out_idx_q == IndexLast) begin
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule
